>>> design/trcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trcb_pkg
// Shared command codes, register indexes, capture modes and the decoded
// command flags passed from the front end to the back end.
// ----------------------------------------------------------------------------
package trcb_pkg;

  // Command codes carried on in_mode
  typedef enum logic [2:0] {
    CMD_SAMPLE  = 3'd0,
    CMD_TRIG    = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_READ    = 3'd5,
    CMD_STATS   = 3'd6
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] REG_CAPTURE_MODE = 2'd0;
  localparam logic [1:0] REG_THRESHOLD    = 2'd1;
  localparam logic [1:0] REG_BUFFER_SIZE  = 2'd2;

  // Capture modes
  localparam logic [1:0] MODE_CONTINUOUS = 2'd0;
  localparam logic [1:0] MODE_TRIGGERED  = 2'd1;
  localparam logic [1:0] MODE_ONESHOT    = 2'd2;

  // Fixed field widths
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned STAT_W      = 32;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned SIZE_FIELD_W = 11;

  // Decoded request, one flag per command; all clear for an unused code
  typedef struct packed {
    logic is_sample;
    logic is_trig;
    logic is_start;
    logic is_stop;
    logic is_clear;
    logic is_read;
    logic is_stats;
  } cmd_flags_t;

  localparam int unsigned FLAGS_W = $bits(cmd_flags_t);

endpackage : trcb_pkg
`default_nettype wire

>>> design/triggered_ring_capture_buffer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triggered_ring_capture_buffer_top
// Ring capture buffer for signed samples with continuous, triggered and
// one-shot capture, chronological reads and saturating statistics.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  mode, sample_value, read_position
//   out_     output     out_valid/out_stall read data, status, statistics
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// One request per cycle sustained while out_stall is low; every request yields one result.
// With no backpressure a request is written into the two-entry queue, sits at
// its head while the execute stage works on it, and then loads the result
// register, from which the result is taken. The sample store is written or
// read at most once per request.
// Reset is synchronous: no clearing pass, the store is only read where
// written. Output stall backs up into the queue; in_stall rises when full.
// ----------------------------------------------------------------------------
module triggered_ring_capture_buffer_top #(
  parameter int unsigned DEPTH        = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [trcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [trcb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // requests
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          in_mode,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_sample_value,
  input  wire logic [trcb_pkg::POS_W-1:0]          in_read_position,
  // results
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           out_read_value,
  output logic                                     out_read_valid,
  output logic [trcb_pkg::COUNT_W-1:0]             out_sample_count,
  output logic                                     out_capturing,
  output logic                                     out_triggered,
  output logic                                     out_overflowed,
  output logic                                     out_auto_stopped,
  output logic                                     out_trigger_fired,
  output logic [trcb_pkg::STAT_W-1:0]              out_captured_total,
  output logic [trcb_pkg::STAT_W-1:0]              out_overflow_total,
  output logic [trcb_pkg::STAT_W-1:0]              out_trigger_total,
  output logic [trcb_pkg::COUNT_W-1:0]             out_peak_usage
);
  import trcb_pkg::*;

  logic                           q_pop;
  logic                           q_valid;
  cmd_flags_t                     q_flags;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;
  logic [POS_W-1:0]               q_pos;

  // Accept and decode requests
  trcb_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_sample_value  (in_sample_value),
    .in_read_position (in_read_position),
    .q_pop            (q_pop),
    .q_valid          (q_valid),
    .q_flags          (q_flags),
    .q_sample         (q_sample),
    .q_pos            (q_pos)
  );

  // Execute requests and present results
  trcb_back #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .q_valid            (q_valid),
    .q_flags            (q_flags),
    .q_sample           (q_sample),
    .q_pos              (q_pos),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_value     (out_read_value),
    .out_read_valid     (out_read_valid),
    .out_sample_count   (out_sample_count),
    .out_capturing      (out_capturing),
    .out_triggered      (out_triggered),
    .out_overflowed     (out_overflowed),
    .out_auto_stopped   (out_auto_stopped),
    .out_trigger_fired  (out_trigger_fired),
    .out_captured_total (out_captured_total),
    .out_overflow_total (out_overflow_total),
    .out_trigger_total  (out_trigger_total),
    .out_peak_usage     (out_peak_usage)
  );

endmodule : triggered_ring_capture_buffer_top
`default_nettype wire

>>> design/trcb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trcb_queue
// Two-entry request queue between the front end and the back end. Push and
// pop may happen in the same cycle, so one request per cycle flows while pops continue.
// ----------------------------------------------------------------------------
module trcb_queue #(
  parameter int unsigned WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_data = slot_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Advance pointers and hold counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 |=> count_r != 2'd0)
    else $error("queue drained from full in one cycle");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("pop from empty request queue");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != 2'd2)
    else $error("push into full request queue");
`endif

endmodule : trcb_queue
`default_nettype wire

>>> design/trcb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trcb_front
// Accept requests, decode the command code into flags and queue them for
// the back end.
// ----------------------------------------------------------------------------
module trcb_front #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [2:0]                        in_mode,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_sample_value,
  input  wire logic [trcb_pkg::POS_W-1:0]        in_read_position,
  input  wire logic                              q_pop,
  output logic                                   q_valid,
  output trcb_pkg::cmd_flags_t                   q_flags,
  output logic signed [SAMPLE_WIDTH-1:0]         q_sample,
  output logic [trcb_pkg::POS_W-1:0]             q_pos
);
  import trcb_pkg::*;

  localparam int unsigned ITEM_W = FLAGS_W + SAMPLE_WIDTH + POS_W;

  cmd_flags_t          dec_flags;
  logic                push;
  logic                full;
  logic [ITEM_W-1:0]   push_data;
  logic [ITEM_W-1:0]   head_data;

  // Decode the command code; an unused code gets no flags
  always_comb begin
    dec_flags = '0;
    unique case (cmd_e'(in_mode))
      CMD_SAMPLE: dec_flags.is_sample = 1'b1;
      CMD_TRIG:   dec_flags.is_trig   = 1'b1;
      CMD_START:  dec_flags.is_start  = 1'b1;
      CMD_STOP:   dec_flags.is_stop   = 1'b1;
      CMD_CLEAR:  dec_flags.is_clear  = 1'b1;
      CMD_READ:   dec_flags.is_read   = 1'b1;
      CMD_STATS:  dec_flags.is_stats  = 1'b1;
      default:    dec_flags = '0;
    endcase
  end

  assign in_stall  = full;
  assign push      = in_valid && !full;
  assign push_data = {dec_flags, in_sample_value, in_read_position};

  trcb_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_data (head_data)
  );

  // Unpack the queue head
  assign q_flags  = cmd_flags_t'(head_data[ITEM_W-1 -: FLAGS_W]);
  assign q_sample = head_data[POS_W +: SAMPLE_WIDTH];
  assign q_pos    = head_data[POS_W-1:0];

endmodule : trcb_front
`default_nettype wire

>>> design/trcb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trcb_back
// Execute one request per cycle while the result slot is free or being taken:
// capture control, ring writes and reads, trigger compare, saturating statistics, result register.
// ----------------------------------------------------------------------------
module trcb_back #(
  parameter int unsigned DEPTH        = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [trcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [trcb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // queue head
  input  wire logic                                q_valid,
  input  wire trcb_pkg::cmd_flags_t                q_flags,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      q_sample,
  input  wire logic [trcb_pkg::POS_W-1:0]          q_pos,
  output logic                                     q_pop,
  // results
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           out_read_value,
  output logic                                     out_read_valid,
  output logic [trcb_pkg::COUNT_W-1:0]             out_sample_count,
  output logic                                     out_capturing,
  output logic                                     out_triggered,
  output logic                                     out_overflowed,
  output logic                                     out_auto_stopped,
  output logic                                     out_trigger_fired,
  output logic [trcb_pkg::STAT_W-1:0]              out_captured_total,
  output logic [trcb_pkg::STAT_W-1:0]              out_overflow_total,
  output logic [trcb_pkg::STAT_W-1:0]              out_trigger_total,
  output logic [trcb_pkg::COUNT_W-1:0]             out_peak_usage
);
  import trcb_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned PW   = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int unsigned CMPW = ((SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W);

  // Configuration
  logic [1:0]                 cap_mode_r, cap_mode_nxt;
  logic signed [THRESH_W-1:0] thresh_r, thresh_nxt;
  logic [CW-1:0]              size_r, size_nxt;
  // Ring state
  logic [AW-1:0]              wp_r, wp_nxt;
  logic [AW-1:0]              base_r, base_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic                       active_r, active_nxt;
  logic                       trig_r, trig_nxt;
  // Statistics
  logic [STAT_W-1:0]          cap_cnt_r, cap_cnt_nxt;
  logic [STAT_W-1:0]          ovf_cnt_r, ovf_cnt_nxt;
  logic [STAT_W-1:0]          trg_cnt_r, trg_cnt_nxt;
  logic [CW-1:0]              peak_r, peak_nxt;
  // Result register
  logic                       o_valid_r;
  logic                       o_rvalid_r, o_over_r, o_astop_r, o_tfired_r;
  logic                       rvalid_nxt, over_nxt, astop_nxt, tfired_nxt;
  logic signed [SAMPLE_WIDTH-1:0] rdata_r;
  // Memory
  logic [SAMPLE_WIDTH-1:0]    store_mem [DEPTH];
  logic                       wr_en;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;

  // Working signals
  logic                       ex_fire;
  logic                       do_write;
  logic                       is_full;
  logic [AW:0]                wp_inc;
  logic [AW-1:0]              wp_wrap;
  logic [PW-1:0]              phys_sum;
  logic [PW-1:0]              phys_adj;
  logic                       pos_hit;
  logic                       trig_hit;
  logic [31:0]                size_req;
  logic [31:0]                size_clamp;

  // Advance when the result slot is free or being taken
  assign ex_fire = q_valid && (!o_valid_r || !out_stall);
  assign q_pop   = ex_fire;

  // Ring pointer helpers
  assign is_full  = (fill_r >= size_r);
  assign wp_inc   = (AW+1)'(wp_r) + (AW+1)'(1);
  assign wp_wrap  = (wp_inc == (AW+1)'(size_r)) ? '0 : wp_inc[AW-1:0];
  assign phys_sum = PW'(base_r) + PW'(q_pos);
  assign phys_adj = (phys_sum >= PW'(size_r)) ? (phys_sum - PW'(size_r)) : phys_sum;
  assign rd_addr  = phys_adj[AW-1:0];
  assign pos_hit  = (32'(q_pos) < 32'(fill_r));
  assign trig_hit = (CMPW'(q_sample) > CMPW'(thresh_r));

  // Clamp a requested buffer size into 1..DEPTH
  assign size_req   = 32'(cfg_wdata[SIZE_FIELD_W-1:0]);
  assign size_clamp = (size_req == 32'd0) ? 32'd1 :
                      ((size_req > 32'(DEPTH)) ? 32'(DEPTH) : size_req);

  // Decide whether this sample request writes the ring or auto-stops a one-shot capture
  always_comb begin
    do_write  = 1'b0;
    astop_nxt = 1'b0;
    if (ex_fire && q_flags.is_sample && active_r) begin
      unique case (cap_mode_r)
        MODE_CONTINUOUS: do_write = 1'b1;
        MODE_TRIGGERED:  do_write = trig_r;
        MODE_ONESHOT: begin
          if (!is_full) begin
            do_write = 1'b1;
          end else begin
            astop_nxt = 1'b1;
          end
        end
        default: do_write = 1'b0;
      endcase
    end
  end

  // Next-state logic for the executed request and configuration writes
  always_comb begin
    cap_mode_nxt = cap_mode_r;
    thresh_nxt   = thresh_r;
    size_nxt     = size_r;
    wp_nxt       = wp_r;
    base_nxt     = base_r;
    fill_nxt     = fill_r;
    active_nxt   = active_r;
    trig_nxt     = trig_r;
    cap_cnt_nxt  = cap_cnt_r;
    ovf_cnt_nxt  = ovf_cnt_r;
    trg_cnt_nxt  = trg_cnt_r;
    peak_nxt     = peak_r;
    rvalid_nxt   = 1'b0;
    over_nxt     = 1'b0;
    tfired_nxt   = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;

    if (do_write) begin
      wr_en       = 1'b1;
      wp_nxt      = wp_wrap;
      cap_cnt_nxt = (cap_cnt_r == '1) ? cap_cnt_r : cap_cnt_r + STAT_W'(1);
      if (is_full) begin
        // overwrite the oldest entry, so the oldest moves along
        over_nxt    = 1'b1;
        base_nxt    = wp_wrap;
        ovf_cnt_nxt = (ovf_cnt_r == '1) ? ovf_cnt_r : ovf_cnt_r + STAT_W'(1);
      end else begin
        fill_nxt = fill_r + CW'(1);
      end
      peak_nxt = (fill_nxt > peak_r) ? fill_nxt : peak_r;
    end

    if (astop_nxt) begin
      active_nxt = 1'b0;
    end

    if (ex_fire) begin
      if (q_flags.is_trig) begin
        if (trig_hit) begin
          trig_nxt    = 1'b1;
          tfired_nxt  = 1'b1;
          trg_cnt_nxt = (trg_cnt_r == '1) ? trg_cnt_r : trg_cnt_r + STAT_W'(1);
        end
      end else if (q_flags.is_start) begin
        active_nxt = 1'b1;
        trig_nxt   = 1'b0;
        wp_nxt     = '0;
        base_nxt   = '0;
        fill_nxt   = '0;
      end else if (q_flags.is_stop) begin
        active_nxt = 1'b0;
        trig_nxt   = 1'b0;
      end else if (q_flags.is_clear) begin
        trig_nxt = 1'b0;
        wp_nxt   = '0;
        base_nxt = '0;
        fill_nxt = '0;
      end else if (q_flags.is_read) begin
        if (pos_hit) begin
          rvalid_nxt = 1'b1;
          rd_en      = 1'b1;
        end
      end else if (q_flags.is_stats) begin
        cap_cnt_nxt = '0;
        ovf_cnt_nxt = '0;
        trg_cnt_nxt = '0;
        peak_nxt    = '0;
      end
    end

    // Write configuration only while no request is in flight; the block does not enforce it.
    if (cfg_we) begin
      if (cfg_index == REG_CAPTURE_MODE) begin
        cap_mode_nxt = cfg_wdata[1:0];
      end else if (cfg_index == REG_THRESHOLD) begin
        thresh_nxt = cfg_wdata;
      end else if (cfg_index == REG_BUFFER_SIZE) begin
        size_nxt = CW'(size_clamp);
        wp_nxt   = '0;
        base_nxt = '0;
        fill_nxt = '0;
      end
    end
  end

  // Hold control state, statistics and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_mode_r <= MODE_CONTINUOUS;
      thresh_r   <= '0;
      size_r     <= CW'(DEPTH);
      wp_r       <= '0;
      base_r     <= '0;
      fill_r     <= '0;
      active_r   <= 1'b0;
      trig_r     <= 1'b0;
      cap_cnt_r  <= '0;
      ovf_cnt_r  <= '0;
      trg_cnt_r  <= '0;
      peak_r     <= '0;
      o_valid_r  <= 1'b0;
    end else begin
      cap_mode_r <= cap_mode_nxt;
      thresh_r   <= thresh_nxt;
      size_r     <= size_nxt;
      wp_r       <= wp_nxt;
      base_r     <= base_nxt;
      fill_r     <= fill_nxt;
      active_r   <= active_nxt;
      trig_r     <= trig_nxt;
      cap_cnt_r  <= cap_cnt_nxt;
      ovf_cnt_r  <= ovf_cnt_nxt;
      trg_cnt_r  <= trg_cnt_nxt;
      peak_r     <= peak_nxt;
      if (ex_fire) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Latch per-request flags with the result
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      o_rvalid_r <= rvalid_nxt;
      o_over_r   <= over_nxt;
      o_astop_r  <= astop_nxt;
      o_tfired_r <= tfired_nxt;
    end
  end

  // Sample store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wp_r] <= q_sample;
    end
    if (rd_en) begin
      rdata_r <= store_mem[rd_addr];
    end
  end

  // Status fields reflect the state left by the request in the result slot
  assign out_valid          = o_valid_r;
  assign out_read_value     = o_rvalid_r ? rdata_r : '0;
  assign out_read_valid     = o_rvalid_r;
  assign out_sample_count   = COUNT_W'(fill_r);
  assign out_capturing      = active_r;
  assign out_triggered      = trig_r;
  assign out_overflowed     = o_over_r;
  assign out_auto_stopped   = o_astop_r;
  assign out_trigger_fired  = o_tfired_r;
  assign out_captured_total = cap_cnt_r;
  assign out_overflow_total = ovf_cnt_r;
  assign out_trigger_total  = trg_cnt_r;
  assign out_peak_usage     = COUNT_W'(peak_r);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= size_r)
    else $error("fill count exceeds buffer size");
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (AW+1)'(wp_r) < (AW+1)'(size_r))
    else $error("write pointer outside ring");
  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && o_over_r |-> fill_r == size_r)
    else $error("overwrite reported while ring not full");
  a_astop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && o_astop_r |-> !active_r)
    else $error("auto stop left capture active");
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && do_write |=> peak_r >= fill_r)
    else $error("peak below fill after write");
`endif

endmodule : trcb_back
`default_nettype wire
